### src/rts_pkg.sv
`default_nettype none

package rts_pkg;

    localparam int TASK_W = 4;
    localparam int RATE_W = 10;
    localparam int TIME_W = 16;
    localparam int TCNT_W = 5;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 1;

    localparam logic [RATE_W-1:0] LOOP_RATE_RESET = RATE_W'(200);

    // request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_GRANT = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_RATE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TASK_COUNT = 1'd1;

endpackage

`default_nettype wire

### src/rts_ram.sv
`default_nettype none

module rts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/rate_task_scheduler_core.sv
// Load: a 10-step divide, one table write, one output load. Start: scans entry by entry
// (ST_SCAN, ST_SCAN_CHK) to a grant or the task limit. Done: with no grant pending, emits
// at once, else reads the entry (ST_DONE_RD, ST_DONE_CHK), emits if the budget runs out,
// or scans on past it. Next request is accepted the cycle after the result loads, even
// while that result waits. Reset (async, active low) clears the loop counter, budget,
// pending grant and last-run valid bits; loop_rate returns to 200 and task_count to 0.
`default_nettype none

module rate_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [rts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [rts_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire logic [1:0]                        req_type,
    input  wire logic [rts_pkg::TASK_W-1:0]        task_index,
    input  wire logic [rts_pkg::RATE_W-1:0]        rate_hz,
    input  wire logic [rts_pkg::TIME_W-1:0]        max_time_us,
    input  wire logic [rts_pkg::TIME_W-1:0]        time_available_us,
    input  wire logic [rts_pkg::TIME_W-1:0]        duration_us,

    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic [1:0]                             result_kind,
    output logic [rts_pkg::TASK_W-1:0]             granted_task,
    output logic                                   slipped,
    output logic                                   overran,
    output logic                                   rerun_now,
    output logic [rts_pkg::TIME_W-1:0]             budget_left
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int CMP_W = CNT_W + rts_pkg::TCNT_W;
    localparam int RW = rts_pkg::RATE_W;
    localparam int TW = rts_pkg::TIME_W;
    localparam int DIV_CNT_W = $clog2(RW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD_WR,
        ST_DONE_RD,
        ST_DONE_CHK,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_EMIT
    } state_t;

    state_t                      state_reg;

    logic [RW-1:0]               loop_rate_reg;
    logic [rts_pkg::TCNT_W-1:0]  task_count_reg;
    logic [TW-1:0]               loop_counter_reg;
    logic [TW-1:0]               budget_reg;
    logic [IDX_W-1:0]            current_task_reg;
    logic                        pending_reg;
    logic [MAX_TASKS-1:0]        lr_valid_reg;

    logic [CNT_W-1:0]            scan_idx_reg;
    logic [DIV_CNT_W-1:0]        div_cnt_reg;
    logic [RW-1:0]               quo_reg;
    logic [RW-1:0]               rem_reg;
    logic [RW-1:0]               divisor_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [TW-1:0]               maxt_reg;
    logic [TW-1:0]               dur_reg;

    logic [1:0]                  st_kind_reg;
    logic [rts_pkg::TASK_W-1:0]  st_task_reg;
    logic                        st_slip_reg;
    logic                        st_over_reg;
    logic                        st_rerun_reg;

    logic                        res_valid_reg;
    logic [1:0]                  result_kind_reg;
    logic [rts_pkg::TASK_W-1:0]  granted_task_reg;
    logic                        slipped_reg;
    logic                        overran_reg;
    logic                        rerun_now_reg;
    logic [TW-1:0]               budget_left_reg;

    // shared datapath signals
    logic [IDX_W-1:0]            scan_addr;
    logic [CNT_W-1:0]            limit;
    logic [RW:0]                 div_shift;
    logic                        div_ge;
    logic [RW-1:0]               iv_new;
    logic [RW+TW-1:0]            cfg_wdata_ram;
    logic [RW+TW-1:0]            cfg_rdata_ram;
    logic [RW-1:0]               rd_iv;
    logic [TW-1:0]               rd_maxt;
    logic [TW-1:0]               last_rdata;
    logic [TW-1:0]               last_run;
    logic [TW-1:0]               dt;
    logic                        grant_hit;
    logic                        last_we;
    logic [IDX_W-1:0]            last_waddr;
    logic [TW-1:0]               last_wdata;
    logic                        req_fire;

    assign scan_addr = scan_idx_reg[IDX_W-1:0];
    assign limit = (CMP_W'(task_count_reg) > CMP_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                                : CNT_W'(task_count_reg);

    assign div_shift = {rem_reg, quo_reg[RW-1]};
    assign div_ge    = div_shift >= {1'b0, divisor_reg};
    assign iv_new    = (quo_reg == '0) ? RW'(1) : quo_reg;

    assign cfg_wdata_ram = {iv_new, maxt_reg};
    assign rd_iv   = cfg_rdata_ram[TW +: RW];
    assign rd_maxt = cfg_rdata_ram[TW-1:0];

    assign last_run  = lr_valid_reg[scan_addr] ? last_rdata : '0;
    assign dt        = loop_counter_reg - last_run;
    assign grant_hit = (dt >= TW'(rd_iv)) && (rd_maxt <= budget_reg);

    assign last_we    = (state_reg == ST_LOAD_WR) || ((state_reg == ST_SCAN_CHK) && grant_hit);
    assign last_waddr = (state_reg == ST_LOAD_WR) ? idx_reg : scan_addr;
    assign last_wdata = (state_reg == ST_LOAD_WR) ? '0 : loop_counter_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    rts_ram #(
        .WIDTH (RW + TW),
        .DEPTH (MAX_TASKS)
    ) u_cfg_ram (
        .clk   (clk),
        .we    (state_reg == ST_LOAD_WR),
        .waddr (idx_reg),
        .wdata (cfg_wdata_ram),
        .raddr (scan_addr),
        .rdata (cfg_rdata_ram)
    );

    rts_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_TASKS)
    ) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (last_waddr),
        .wdata (last_wdata),
        .raddr (scan_addr),
        .rdata (last_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            loop_rate_reg    <= rts_pkg::LOOP_RATE_RESET;
            task_count_reg   <= '0;
            loop_counter_reg <= '0;
            budget_reg       <= '0;
            current_task_reg <= '0;
            pending_reg      <= 1'b0;
            lr_valid_reg     <= '0;
            scan_idx_reg     <= '0;
            div_cnt_reg      <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            divisor_reg      <= '0;
            idx_reg          <= '0;
            maxt_reg         <= '0;
            dur_reg          <= '0;
            st_kind_reg      <= rts_pkg::KIND_ACK;
            st_task_reg      <= '0;
            st_slip_reg      <= 1'b0;
            st_over_reg      <= 1'b0;
            st_rerun_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            result_kind_reg  <= rts_pkg::KIND_ACK;
            granted_task_reg <= '0;
            slipped_reg      <= 1'b0;
            overran_reg      <= 1'b0;
            rerun_now_reg    <= 1'b0;
            budget_left_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    rts_pkg::CFG_LOOP_RATE:  loop_rate_reg  <= cfg_wdata[RW-1:0];
                    rts_pkg::CFG_TASK_COUNT: task_count_reg <= cfg_wdata[rts_pkg::TCNT_W-1:0];
                    default: ;
                endcase
            end

            if (last_we)
            begin
                lr_valid_reg[last_waddr] <= 1'b1;
            end

            // ST_EMIT drives the valid itself
            if (res_ready && (state_reg != ST_EMIT))
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        st_task_reg  <= '0;
                        st_slip_reg  <= 1'b0;
                        st_over_reg  <= 1'b0;
                        st_rerun_reg <= 1'b0;
                        maxt_reg     <= max_time_us;
                        dur_reg      <= duration_us;
                        idx_reg      <= IDX_W'(task_index);
                        unique case (req_type)
                            rts_pkg::REQ_LOAD:
                            begin
                                st_kind_reg <= rts_pkg::KIND_ACK;
                                if (int'(task_index) < MAX_TASKS)
                                begin
                                    quo_reg     <= loop_rate_reg;
                                    rem_reg     <= '0;
                                    divisor_reg <= (rate_hz == '0) ? RW'(1) : rate_hz;
                                    div_cnt_reg <= DIV_CNT_W'(RW - 1);
                                    state_reg   <= ST_DIV;
                                end
                                else
                                begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            rts_pkg::REQ_START:
                            begin
                                st_kind_reg      <= rts_pkg::KIND_END;
                                loop_counter_reg <= loop_counter_reg + TW'(1);
                                budget_reg       <= time_available_us;
                                pending_reg      <= 1'b0;
                                scan_idx_reg     <= '0;
                                state_reg        <= ST_SCAN;
                            end
                            rts_pkg::REQ_DONE:
                            begin
                                st_kind_reg <= rts_pkg::KIND_END;
                                if (pending_reg)
                                begin
                                    pending_reg  <= 1'b0;
                                    scan_idx_reg <= CNT_W'(current_task_reg);
                                    state_reg    <= ST_DONE_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            default:
                            begin
                                st_kind_reg <= rts_pkg::KIND_END;
                                state_reg   <= ST_EMIT;
                            end
                        endcase
                    end
                end

                // restoring divide, one quotient bit per cycle
                ST_DIV:
                begin
                    quo_reg <= {quo_reg[RW-2:0], div_ge};
                    rem_reg <= div_ge ? RW'(div_shift - {1'b0, divisor_reg})
                                      : div_shift[RW-1:0];
                    div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= ST_LOAD_WR;
                    end
                end

                ST_LOAD_WR:
                begin
                    state_reg <= ST_EMIT;
                end

                ST_DONE_RD:
                begin
                    state_reg <= ST_DONE_CHK;
                end

                ST_DONE_CHK:
                begin
                    st_over_reg <= dur_reg > rd_maxt;
                    if (dur_reg >= budget_reg)
                    begin
                        budget_reg   <= '0;
                        st_rerun_reg <= 1'b1;
                        state_reg    <= ST_EMIT;
                    end
                    else
                    begin
                        budget_reg   <= budget_reg - dur_reg;
                        scan_idx_reg <= CNT_W'(current_task_reg) + CNT_W'(1);
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (scan_idx_reg >= limit)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                end

                ST_SCAN_CHK:
                begin
                    if (grant_hit)
                    begin
                        current_task_reg <= scan_addr;
                        pending_reg      <= 1'b1;
                        st_kind_reg      <= rts_pkg::KIND_GRANT;
                        st_task_reg      <= rts_pkg::TASK_W'(scan_addr);
                        st_slip_reg      <= dt >= TW'({rd_iv, 1'b0});
                        state_reg        <= ST_EMIT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                        state_reg    <= ST_SCAN;
                    end
                end

                ST_EMIT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg    <= 1'b1;
                        result_kind_reg  <= st_kind_reg;
                        granted_task_reg <= st_task_reg;
                        slipped_reg      <= st_slip_reg;
                        overran_reg      <= st_over_reg;
                        rerun_now_reg    <= st_rerun_reg;
                        budget_left_reg  <= budget_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_kind  = result_kind_reg;
    assign granted_task = granted_task_reg;
    assign slipped      = slipped_reg;
    assign overran      = overran_reg;
    assign rerun_now    = rerun_now_reg;
    assign budget_left  = budget_left_reg;

endmodule

`default_nettype wire

### src/rts_checker.sv
`default_nettype none

module rts_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    input  wire logic                              req_ready,
    input  wire logic                              res_valid,
    input  wire logic                              res_ready,
    input  wire logic [1:0]                        result_kind,
    input  wire logic [rts_pkg::TASK_W-1:0]        granted_task,
    input  wire logic                              slipped,
    input  wire logic                              overran,
    input  wire logic                              rerun_now,
    input  wire logic [rts_pkg::TIME_W-1:0]        budget_left
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_kind)
            && $stable(granted_task) && $stable(budget_left))
        else $error("result changed while stalled");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_rerun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && rerun_now |-> result_kind == rts_pkg::KIND_END && budget_left == '0)
        else $error("rerun without exhausted budget");

    a_nogrant: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind != rts_pkg::KIND_GRANT |-> granted_task == '0 && !slipped)
        else $error("grant fields set on non-grant result");

    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result_kind == rts_pkg::KIND_ACK |-> !overran && !rerun_now)
        else $error("flags set on load acknowledge");

endmodule

bind rate_task_scheduler_core rts_checker u_rts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_kind  (result_kind),
    .granted_task (granted_task),
    .slipped      (slipped),
    .overran      (overran),
    .rerun_now    (rerun_now),
    .budget_left  (budget_left)
);

`default_nettype wire

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENTRIES = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // worst request: load divide plus a full table scan
    localparam int SETTLE = 2 * MAX_ENTRIES + 4 + 14;
    localparam int LONG_HOLD = 120;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]                 op;
        logic [rts_pkg::TASK_W-1:0] idx;
        logic [rts_pkg::RATE_W-1:0] rate;
        logic [rts_pkg::TIME_W-1:0] maxt;
        logic [rts_pkg::TIME_W-1:0] avail;
        logic [rts_pkg::TIME_W-1:0] dur;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [rts_pkg::TASK_W-1:0] task_id;
        logic                       slip;
        logic                       over;
        logic                       rerun;
        logic [rts_pkg::TIME_W-1:0] budget;
    } reply_t;

    typedef struct {
        bit                             is_cfg;
        logic [rts_pkg::CFG_ADDR_W-1:0] sel;
        logic [rts_pkg::CFG_DATA_W-1:0] val;
        sched_req_t                     rq;
        bit                             known;
        reply_t                         want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rts_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [rts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [1:0] req_type = '0;
    logic [rts_pkg::TASK_W-1:0] task_index = '0;
    logic [rts_pkg::RATE_W-1:0] rate_hz = '0;
    logic [rts_pkg::TIME_W-1:0] max_time_us = '0;
    logic [rts_pkg::TIME_W-1:0] time_available_us = '0;
    logic [rts_pkg::TIME_W-1:0] duration_us = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [1:0] result_kind;
    logic [rts_pkg::TASK_W-1:0] granted_task;
    logic slipped;
    logic overran;
    logic rerun_now;
    logic [rts_pkg::TIME_W-1:0] budget_left;

    // scheduler shadow state
    int m_loop_rate = int'(rts_pkg::LOOP_RATE_RESET);
    int m_task_cnt = 0;
    logic [rts_pkg::TIME_W-1:0] m_loop_cnt = '0;
    int m_interval [MAX_ENTRIES] = '{default: 0};
    logic [rts_pkg::TIME_W-1:0] m_max_time [MAX_ENTRIES] = '{default: '0};
    logic [rts_pkg::TIME_W-1:0] m_last_run [MAX_ENTRIES] = '{default: '0};
    logic [rts_pkg::TIME_W-1:0] m_budget = '0;
    int m_cur = 0;
    bit m_pending = 1'b0;

    reply_t awaited[$];
    reply_t blank_reply = '0;
    dir_row_t plan[$];
    int mismatches = 0;
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    rate_task_scheduler_core #(.MAX_TASKS(MAX_ENTRIES)) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req_type          (req_type),
        .task_index        (task_index),
        .rate_hz           (rate_hz),
        .max_time_us       (max_time_us),
        .time_available_us (time_available_us),
        .duration_us       (duration_us),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .result_kind       (result_kind),
        .granted_task      (granted_task),
        .slipped           (slipped),
        .overran           (overran),
        .rerun_now         (rerun_now),
        .budget_left       (budget_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // grant the first due entry from 'first' on that fits the budget
    function automatic reply_t scan_entries(int first, logic over);
        reply_t r;
        int lim;
        logic [rts_pkg::TIME_W-1:0] dt;
        r = '0;
        lim = (m_task_cnt > MAX_ENTRIES) ? MAX_ENTRIES : m_task_cnt;
        for (int i = first; i < lim; i++)
        begin
            dt = m_loop_cnt - m_last_run[i];
            if (dt >= m_interval[i] && m_max_time[i] <= m_budget)
            begin
                m_last_run[i] = m_loop_cnt;
                m_cur = i;
                m_pending = 1'b1;
                r.kind = rts_pkg::KIND_GRANT;
                r.task_id = 4'(i);
                r.slip = (dt >= 2 * m_interval[i]);
                r.over = over;
                return r;
            end
        end
        r.kind = rts_pkg::KIND_END;
        r.over = over;
        return r;
    endfunction

    function automatic reply_t step_schedule(sched_req_t rq);
        reply_t r;
        int iv;
        logic over;
        r = '0;
        r.kind = rts_pkg::KIND_END;
        case (rq.op)
            rts_pkg::REQ_LOAD:
            begin
                iv = m_loop_rate / ((rq.rate == 0) ? 1 : int'(rq.rate));
                m_interval[rq.idx] = (iv < 1) ? 1 : iv;
                m_max_time[rq.idx] = rq.maxt;
                m_last_run[rq.idx] = '0;
                r.kind = rts_pkg::KIND_ACK;
            end
            rts_pkg::REQ_START:
            begin
                m_loop_cnt = m_loop_cnt + 1'b1;
                m_budget = rq.avail;
                m_pending = 1'b0;
                r = scan_entries(0, 1'b0);
            end
            rts_pkg::REQ_DONE:
            begin
                if (m_pending)
                begin
                    m_pending = 1'b0;
                    over = (rq.dur > m_max_time[m_cur]);
                    if (rq.dur >= m_budget)
                    begin
                        m_budget = '0;
                        r.over = over;
                        r.rerun = 1'b1;
                    end
                    else
                    begin
                        m_budget = m_budget - rq.dur;
                        r = scan_entries(m_cur + 1, over);
                    end
                end
            end
            default: ;
        endcase
        r.budget = m_budget;
        return r;
    endfunction

    function automatic sched_req_t random_request(logic [1:0] op);
        sched_req_t rq;
        rq.op = op;
        rq.idx = 4'($urandom);
        rq.rate = 10'($urandom);
        rq.maxt = 16'($urandom);
        rq.avail = 16'($urandom);
        rq.dur = 16'($urandom);
        return rq;
    endfunction

    // rates mostly high enough that intervals stay short and tasks come due
    function automatic sched_req_t random_load(logic [rts_pkg::TASK_W-1:0] slot);
        sched_req_t rq;
        rq = random_request(rts_pkg::REQ_LOAD);
        rq.idx = slot;
        case ($urandom_range(0, 5))
            0: rq.rate = '0;
            1: rq.rate = '1;
            2: ;
            default: rq.rate = 10'($urandom_range(m_loop_rate / 4 + 1, 1023));
        endcase
        case ($urandom_range(0, 5))
            0: rq.maxt = '0;
            1: rq.maxt = '1;
            2: ;
            default: rq.maxt = 16'($urandom_range(0, 400));
        endcase
        return rq;
    endfunction

    function automatic void add_cfg(logic [rts_pkg::CFG_ADDR_W-1:0] sel,
                                    logic [rts_pkg::CFG_DATA_W-1:0] val);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.sel = sel;
        row.val = val;
        plan.push_back(row);
    endfunction

    function automatic void add_req(logic [1:0] op, logic [rts_pkg::TASK_W-1:0] idx,
                                    logic [rts_pkg::RATE_W-1:0] rate,
                                    logic [rts_pkg::TIME_W-1:0] maxt,
                                    logic [rts_pkg::TIME_W-1:0] avail,
                                    logic [rts_pkg::TIME_W-1:0] dur,
                                    bit known, logic [1:0] kind,
                                    logic [rts_pkg::TIME_W-1:0] budget);
        dir_row_t row;
        row = '{default: '0};
        row.rq = '{op, idx, rate, maxt, avail, dur};
        row.known = known;
        row.want = '{kind, '0, 1'b0, 1'b0, 1'b0, budget};
        plan.push_back(row);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input sched_req_t rq, input bit known, input reply_t want);
        reply_t p;
        req_valid <= 1'b1;
        req_type <= rq.op;
        task_index <= rq.idx;
        rate_hz <= rq.rate;
        max_time_us <= rq.maxt;
        time_available_us <= rq.avail;
        duration_us <= rq.dur;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = step_schedule(rq);
        awaited.push_back(known ? want : p);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rts_pkg::CFG_ADDR_W-1:0] sel,
                             input logic [rts_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= sel;
        cfg_wdata <= val;
        if (sel == rts_pkg::CFG_LOOP_RATE)
            m_loop_rate = int'(val);
        else
            m_task_cnt = int'(val[rts_pkg::TCNT_W-1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [rts_pkg::CFG_DATA_W-1:0] rate_val,
                             input logic [rts_pkg::CFG_DATA_W-1:0] count_val,
                             input bit reload, input bit squeeze, input int n_items);
        sched_req_t rq;
        int pick;
        settle();
        write_reg(rts_pkg::CFG_LOOP_RATE, rate_val);
        write_reg(rts_pkg::CFG_TASK_COUNT, count_val);
        if (reload)
        begin
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                issue(random_load(4'(k)), 1'b0, blank_reply);
                maybe_gap();
            end
        end
        long_hold = squeeze;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (m_pending && pick < 80)
            begin
                rq = random_request(rts_pkg::REQ_DONE);
                case ($urandom_range(0, 9))
                    0: rq.dur = '0;
                    1: rq.dur = '1;
                    2, 3: rq.dur = 16'($urandom_range(0, m_budget));
                    default: rq.dur = 16'($urandom_range(0, m_budget / 4 + 20));
                endcase
            end
            else if (!m_pending && pick < 70)
            begin
                rq = random_request(rts_pkg::REQ_START);
                case ($urandom_range(0, 9))
                    0: rq.avail = '0;
                    1: rq.avail = '1;
                    default: rq.avail = 16'($urandom_range(20, 3000));
                endcase
            end
            else
            begin
                // stray traffic: reloads mid-loop, bad type, dropped grants
                case ($urandom_range(0, 3))
                    0: rq = random_load(4'($urandom));
                    1: rq = random_request(REQ_UNUSED);
                    2: rq = random_request(rts_pkg::REQ_START);
                    default: rq = random_request(rts_pkg::REQ_DONE);
                endcase
            end
            issue(rq, 1'b0, blank_reply);
            maybe_gap();
        end
    endtask

    // response side: random stalls, plus one long hold to back up the request path
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && res_valid && res_ready)
        begin
            got = '{result_kind, granted_task, slipped, overran, rerun_now, budget_left};
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: kind %0d task %0d slip %0b over %0b",
                             got.kind, got.task_id, got.slip, got.over,
                             " rerun %0b budget %0d", got.rerun, got.budget);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.task_id !== want.task_id ||
                    got.slip !== want.slip || got.over !== want.over ||
                    got.rerun !== want.rerun || got.budget !== want.budget)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t reply mismatch: exp kind %0d task %0d slip %0b",
                                 $realtime, want.kind, want.task_id, want.slip,
                                 " over %0b rerun %0b budget %0d", want.over, want.rerun,
                                 want.budget,
                                 " / got kind %0d task %0d slip %0b", got.kind,
                                 got.task_id, got.slip,
                                 " over %0b rerun %0b budget %0d", got.over, got.rerun,
                                 got.budget);
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int load_rate [MAX_ENTRIES];
        int load_max [MAX_ENTRIES];
        dir_row_t row;
        load_rate = '{0, 1000, 1023, 1, 100, 200, 50, 512, 3, 7, 400, 66, 999, 2, 150, 20};
        load_max = '{0, 65535, 0, 10, 5, 0, 100, 32768, 1, 300, 40, 200, 65534, 7, 64, 15};

        // empty table: stray done, bad type, start with nothing to grant
        add_req(rts_pkg::REQ_DONE, 4'd0, '0, '0, '0, 16'hFFFF, 1'b1,
                rts_pkg::KIND_END, 16'd0);
        add_req(REQ_UNUSED, 4'd15, '1, '1, '1, '1, 1'b1, rts_pkg::KIND_END, 16'd0);
        add_req(rts_pkg::REQ_START, 4'd0, '0, '0, 16'hFFFF, '0, 1'b1,
                rts_pkg::KIND_END, 16'hFFFF);
        add_req(rts_pkg::REQ_DONE, 4'd0, '0, '0, '0, '0, 1'b1, rts_pkg::KIND_END, 16'hFFFF);
        // fill every entry before any scan can reach it
        for (int k = 0; k < MAX_ENTRIES; k++)
            add_req(rts_pkg::REQ_LOAD, 4'(k), 10'(load_rate[k]), 16'(load_max[k]), '0, '0,
                    1'b1, rts_pkg::KIND_ACK, 16'hFFFF);
        add_cfg(rts_pkg::CFG_TASK_COUNT, 10'd16);
        add_req(rts_pkg::REQ_START, '0, '0, '0, 16'd0, '0, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_DONE, '0, '0, '0, '0, 16'hFFFF, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_START, '0, '0, '0, 16'd40000, '0, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_START, '0, '0, '0, 16'hFFFF, '0, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_DONE, '0, '0, '0, '0, 16'd0, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_DONE, '0, '0, '0, '0, 16'd1000, 1'b0, rts_pkg::KIND_ACK, '0);
        add_req(rts_pkg::REQ_DONE, '0, '0, '0, '0, 16'hFFFE, 1'b0, rts_pkg::KIND_ACK, '0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.sel, row.val);
            end
            else
            begin
                issue(row.rq, row.known, row.want);
                maybe_gap();
            end
        end

        run_phase(10'd1000, 10'd16, 1'b1, 1'b0, 90);
        run_phase(10'd1, 10'($urandom_range(1, 15)), 1'b1, 1'b0, 90);

        // no reload: last-run counts and intervals carry over from the earlier phase
        run_phase(10'd0, 10'h3FF, 1'b0, 1'b0, 90);
        run_phase(10'd1023, 10'h3E8, 1'b1, 1'b1, 90);
        idle_on = 1'b0;
        run_phase(10'd200, 10'd16, 1'b1, 1'b0, 90);

        settle();
        if (mismatches == 0 && awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
src/rts_pkg.sv
src/rts_ram.sv
src/rate_task_scheduler_core.sv
src/rts_checker.sv
verif/tb_top.sv
